[rtl/first_fit_heap_allocator_core_defines.svh]
// assertion macros used by the allocator datapath
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int FFHA_MAX_BLOCKS   = 64;
    localparam int FFHA_HEADER_BYTES = 12;

    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 8'd1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result source selects from controller to datapath
    localparam logic [2:0] RES_TRIVIAL = 3'd0;
    localparam logic [2:0] RES_HIT     = 3'd1;
    localparam logic [2:0] RES_UNKNOWN = 3'd2;
    localparam logic [2:0] RES_FULL    = 3'd3;
    localparam logic [2:0] RES_EXHAUST = 3'd4;
    localparam logic [2:0] RES_APPEND  = 3'd5;

    typedef struct packed {
        logic        is_free;
        logic [31:0] bytes;
        logic [31:0] start;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       check;
        logic       scan;
        logic       commit;
        logic       append;
        logic       res_set;
        logic [2:0] res_code;
        logic       out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_free_req;
        logic null_req;
        logic empty;
        logic hit;
        logic miss_end;
        logic full;
        logic exhausted;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/ffha_ctrl.sv]
// request sequencer of the first-fit heap allocator
`timescale 1ns / 1ps

module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_stall
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_NOFIT  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.null_req) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = RES_TRIVIAL;
                    n_state        = S_RESULT;
                end else if (i_status.empty) begin
                    if (i_status.is_free_req) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = RES_UNKNOWN;
                        n_state        = S_RESULT;
                    end else begin
                        n_state = S_NOFIT;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = RES_HIT;
                    n_state        = S_RESULT;
                end else if (i_status.miss_end) begin
                    if (i_status.is_free_req) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = RES_UNKNOWN;
                        n_state        = S_RESULT;
                    end else begin
                        n_state = S_NOFIT;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_NOFIT: begin
                o_cmd.res_set = 1'b1;
                // table full is reported ahead of the limit check
                if (i_status.full) begin
                    o_cmd.res_code = RES_FULL;
                end else if (i_status.exhausted) begin
                    o_cmd.res_code = RES_EXHAUST;
                end else begin
                    o_cmd.append   = 1'b1;
                    o_cmd.res_code = RES_APPEND;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ffha_dp.sv]
// block table, break pointer, config and result registers of the allocator
`timescale 1ns / 1ps

`include "first_fit_heap_allocator_core_defines.svh"

module ffha_dp
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = FFHA_MAX_BLOCKS,
    parameter int HEADER_BYTES = FFHA_HEADER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_kind,
    input  logic [31:0]          i_req_size,
    input  logic [31:0]          i_address,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [31:0]          o_payload_address,
    output logic [2:0]           o_status_code
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [31:0]   HDR32   = 32'(HEADER_BYTES);
    localparam logic [32:0]   HDR33   = 33'(HEADER_BYTES);
    localparam logic [33:0]   HDR34   = 34'(HEADER_BYTES);

    t_entry r_mem [MAX_BLOCKS];

    logic        r_kind;
    logic [32:0] r_rounded;
    logic [31:0] r_addr;
    logic [33:0] r_need;
    logic [31:0] r_heap_base;
    logic [31:0] r_heap_limit;
    logic [CW-1:0] r_count;
    logic [31:0] r_break;
    logic [CW-1:0] r_ridx;
    logic [CW-1:0] r_didx;
    logic        r_dvalid;
    t_entry      r_rdata;
    logic [31:0] r_res_addr;
    logic [2:0]  r_res_status;
    logic        r_ovalid;
    logic [31:0] r_opayload;
    logic [2:0]  r_ostatus;

    logic [32:0] rounded_in;
    logic [31:0] cur;
    logic [33:0] next_break;
    logic        match;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry      mem_wdata;

    // round up to a multiple of four at 33 bits so huge sizes do not wrap
    assign rounded_in = ({1'b0, i_req_size} + 33'd3) & ~33'd3;

    assign cur        = (r_count == '0) ? r_heap_base : r_break;
    assign next_break = {2'b00, cur} + r_need;

    always_comb begin
        if (r_kind == KIND_FREE) begin
            match = (({1'b0, r_rdata.start} + HDR33) == {1'b0, r_addr});
        end else begin
            match = r_rdata.is_free && ({1'b0, r_rdata.bytes} >= r_rounded);
        end
    end

    assign o_status.is_free_req = (r_kind == KIND_FREE);
    assign o_status.null_req    = (r_kind == KIND_FREE) ? (r_addr == '0) : (r_rounded == '0);
    assign o_status.empty       = (r_count == '0);
    assign o_status.hit         = r_dvalid && match;
    assign o_status.miss_end    = r_dvalid && !match && ((r_didx + CW'(1)) == r_count);
    assign o_status.full        = (r_count == CNT_MAX);
    assign o_status.exhausted   = (next_break > {2'b00, r_heap_limit});
    assign o_status.out_free    = !r_ovalid || !i_stall;

    // one write port: mark a found entry, or append a new one
    always_comb begin
        mem_we    = i_cmd.commit || i_cmd.append;
        mem_waddr = r_didx[IW-1:0];
        mem_wdata = r_rdata;
        if (i_cmd.append) begin
            mem_waddr         = r_count[IW-1:0];
            mem_wdata.is_free = 1'b0;
            mem_wdata.bytes   = r_rounded[31:0];
            mem_wdata.start   = cur;
        end else begin
            mem_wdata.is_free = r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.scan) begin
            r_rdata <= r_mem[r_ridx[IW-1:0]];
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_rounded <= rounded_in;
            r_addr    <= i_address;
        end
        if (i_cmd.check) begin
            r_need <= {1'b0, r_rounded} + HDR34;
        end
        if (i_cmd.scan) begin
            r_didx <= r_ridx;
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_code)
                RES_TRIVIAL: begin
                    r_res_addr   <= '0;
                    r_res_status <= (r_kind == KIND_FREE) ? ST_OK : ST_ZERO;
                end
                RES_HIT: begin
                    r_res_addr   <= (r_kind == KIND_FREE) ? '0 : (r_rdata.start + HDR32);
                    r_res_status <= ST_OK;
                end
                RES_UNKNOWN: begin
                    r_res_addr   <= '0;
                    r_res_status <= ST_UNKNOWN;
                end
                RES_FULL: begin
                    r_res_addr   <= '0;
                    r_res_status <= ST_FULL;
                end
                RES_EXHAUST: begin
                    r_res_addr   <= '0;
                    r_res_status <= ST_EXHAUSTED;
                end
                RES_APPEND: begin
                    r_res_addr   <= cur + HDR32;
                    r_res_status <= ST_OK;
                end
                default: begin
                    r_res_addr   <= '0;
                    r_res_status <= ST_OK;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_opayload <= r_res_addr;
            r_ostatus  <= r_res_status;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= '1;
            r_count      <= '0;
            r_break      <= '0;
            r_ridx       <= '0;
            r_dvalid     <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                    REG_HEAP_LIMIT: r_heap_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.check) begin
                r_ridx   <= '0;
                r_dvalid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_ridx   <= r_ridx + CW'(1);
                r_dvalid <= 1'b1;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
                r_break <= next_break[31:0];
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_payload_address = r_opayload;
    assign o_status_code     = r_ostatus;

    `FFHA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX, "block count above table depth")
    `FFHA_ASSERT_IMP(a_append_room, i_clk, i_rst_n, i_cmd.append, r_count < CNT_MAX, "append into a full table")
    `FFHA_ASSERT_IMP(a_commit_data, i_clk, i_rst_n, i_cmd.commit, r_dvalid && (r_didx < r_count), "commit without a valid table read")
    `FFHA_ASSERT_NXT(a_append_count, i_clk, i_rst_n, i_cmd.append, r_count == ($past(r_count) + CW'(1)), "append did not advance the count")
    `FFHA_ASSERT_IMP(a_load_slot, i_clk, i_rst_n, i_cmd.out_load, !r_ovalid || !i_stall, "result written over an untaken one")

endmodule

[rtl/first_fit_heap_allocator_core.sv]
// First-fit heap allocator. One request (allocate or free) is taken at a time and gives one
// result. An allocate with size zero and a free of address zero are answered without a scan;
// any other request scans the block table, held in a single-port-read memory, one entry per
// cycle in creation order, when the table holds entries. The finished result sits in an output
// register, so a waiting result does not hold up the scan of the next request once it is taken
// in. The table needs no clearing after reset: only entries below the block count are ever read.
// Configuration writes are always ready and must only be made while no request is in flight.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = FFHA_MAX_BLOCKS,
    parameter int HEADER_BYTES = FFHA_HEADER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [31:0]          i_req_size,
    input  logic [31:0]          i_address,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_payload_address,
    output logic [2:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    ffha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (dp_status),
        .i_kind            (i_kind),
        .i_req_size        (i_req_size),
        .i_address         (i_address),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_payload_address (o_payload_address),
        .o_status_code     (o_status)
    );

endmodule

[tb/first_fit_heap_allocator_core_tb.sv]
// self-checking testbench of the first-fit heap allocator core: directed table, then random phases
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    localparam int MAX_BLOCKS    = FFHA_MAX_BLOCKS;
    localparam int SETTLE_CYCLES = FFHA_MAX_BLOCKS + 8;
    localparam int DRAIN_LIMIT   = 20000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hff;

    typedef struct packed {
        logic [31:0] payload;
        logic [2:0]  status;
    } grant_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;

    typedef struct {
        row_op_e              op;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
        logic                 kind;
        logic [31:0]          size;
        logic [31:0]          addr;
        bit                   typed;
        grant_t               want;
    } stim_row_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_kind      = KIND_ALLOC;
    logic [31:0]          i_req_size  = '0;
    logic [31:0]          i_address   = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [31:0]          o_payload_address;
    logic [2:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    // shadow of the allocator state
    logic [31:0] heap_start [MAX_BLOCKS];
    logic [31:0] heap_bytes [MAX_BLOCKS];
    logic        heap_free  [MAX_BLOCKS];
    int          heap_blocks = 0;
    logic [32:0] heap_break  = '0;
    logic [31:0] heap_base   = '0;
    logic [31:0] heap_limit  = '1;

    grant_t    grant_q[$];
    stim_row_t dir_rows[$];

    bit calm = 1'b0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int status_seen [8];

    first_fit_heap_allocator_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_req_size        (i_req_size),
        .i_address         (i_address),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_payload_address (o_payload_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // first-fit search over the shadow table, then append at the break; frees look up the payload address
    task automatic predict_grant(input logic kind, input logic [31:0] size,
                                 input logic [31:0] addr, output grant_t res);
        logic [32:0] rounded;
        logic [32:0] cur;
        logic [33:0] nxt;
        bit          done;
        res  = '{32'd0, ST_OK};
        done = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (size == 32'd0) begin
                res.status = ST_ZERO;
            end else begin
                rounded = ({1'b0, size} + 33'd3) & ~33'd3;
                for (int i = 0; i < heap_blocks && !done; i++) begin
                    if (heap_free[i] && {1'b0, heap_bytes[i]} >= rounded) begin
                        heap_free[i] = 1'b0;
                        res.payload  = heap_start[i] + 32'(FFHA_HEADER_BYTES);
                        done         = 1'b1;
                    end
                end
                if (!done) begin
                    if (heap_blocks >= MAX_BLOCKS) begin
                        res.status = ST_FULL;
                    end else begin
                        cur = (heap_blocks == 0) ? {1'b0, heap_base} : heap_break;
                        nxt = {1'b0, cur} + {1'b0, rounded} + 34'(FFHA_HEADER_BYTES);
                        if (nxt > {2'b00, heap_limit}) begin
                            res.status = ST_EXHAUSTED;
                        end else begin
                            heap_start[heap_blocks] = cur[31:0];
                            heap_bytes[heap_blocks] = rounded[31:0];
                            heap_free[heap_blocks]  = 1'b0;
                            heap_blocks++;
                            heap_break  = nxt[32:0];
                            res.payload = cur[31:0] + 32'(FFHA_HEADER_BYTES);
                        end
                    end
                end
            end
        end else if (addr != 32'd0) begin
            res.status = ST_UNKNOWN;
            for (int i = 0; i < heap_blocks && !done; i++) begin
                if ({1'b0, heap_start[i]} + 33'(FFHA_HEADER_BYTES) == {1'b0, addr}) begin
                    heap_free[i] = 1'b1;
                    res.status   = ST_OK;
                    done         = 1'b1;
                end
            end
        end
    endtask

    function automatic logic [31:0] next_header();
        return (heap_blocks == 0) ? heap_base : heap_break[31:0];
    endfunction

    function automatic logic [31:0] limit_above_break(input int lo, input int hi);
        logic [32:0] sum;
        sum = {1'b0, next_header()} + 33'($urandom_range(lo, hi));
        return sum[32] ? 32'hffff_ffff : sum[31:0];
    endfunction

    function automatic void add_req(input logic kind, input logic [31:0] size,
                                    input logic [31:0] addr, input bit typed,
                                    input grant_t want);
        dir_rows.push_back('{ROW_REQ, '0, '0, kind, size, addr, typed, want});
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        dir_rows.push_back('{ROW_CFG, index, data, KIND_ALLOC, '0, '0, 1'b0, '0});
    endfunction

    // one request transfer; caller is at a rising edge
    task automatic send_request(input logic kind, input logic [31:0] size,
                                input logic [31:0] addr, input bit typed, input grant_t want);
        grant_t res;
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_req_size <= size;
        i_address  <= addr;
        do @(posedge i_clk); while (o_stall);
        predict_grant(kind, size, addr, res);
        grant_q.push_back(typed ? want : res);
        requests_sent++;
    endtask

    // register write, only once the block has gone quiet
    task automatic set_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        i_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == REG_HEAP_BASE) begin
            heap_base = data;
        end else if (index == REG_HEAP_LIMIT) begin
            heap_limit = data;
        end
    endtask

    // mostly allocates and frees of live blocks, with some noise frees
    task automatic random_request();
        int          pick;
        int          r;
        int          idx;
        logic        kind;
        logic [31:0] size;
        logic [31:0] addr;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        size = $urandom;
        addr = $urandom;
        if (pick < 50) begin
            kind = KIND_ALLOC;
            if (r < 70) begin
                size = $urandom_range(1, 64);
            end else if (r < 85) begin
                size = $urandom_range(65, 1024);
            end else if (r < 90) begin
                size = 32'd0;
            end else if (r < 95) begin
                size = $urandom;
            end else begin
                size = 32'hffff_ffff - 32'($urandom_range(0, 3));
            end
        end else begin
            kind = KIND_FREE;
            idx  = (heap_blocks > 0) ? $urandom_range(0, heap_blocks - 1) : 0;
            if (pick < 90) begin
                addr = (heap_blocks > 0) ? heap_start[idx] + 32'(FFHA_HEADER_BYTES) : 32'd0;
            end else if (r < 30) begin
                addr = 32'd0;
            end else if (r < 60 && heap_blocks > 0) begin
                // near miss of a live payload address
                addr = heap_start[idx] + 32'(FFHA_HEADER_BYTES) + ((r & 1) ? 32'd4 : -32'd4);
            end
        end
        send_request(kind, size, addr, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    always @(posedge i_clk) begin
        grant_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (grant_q.size() == 0) begin
                $error("result with no request outstanding: payload_address %h status %0d",
                       o_payload_address, o_status);
                mismatches++;
            end else begin
                want = grant_q.pop_front();
                if (o_payload_address !== want.payload) begin
                    $error("payload_address: expected %h, actual %h",
                           want.payload, o_payload_address);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
                status_seen[o_status]++;
                results_seen++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("** first_fit_heap_allocator_core: FAILED **");
        $finish;
    end

    initial begin
        int drain_cycles;

        // empty table, reset settings
        add_req(KIND_ALLOC, 32'd0, 32'hffff_ffff, 1'b1, '{32'd0, ST_ZERO});
        add_req(KIND_FREE, 32'hffff_ffff, 32'd0, 1'b1, '{32'd0, ST_OK});
        add_req(KIND_FREE, 32'd0, 32'hffff_ffff, 1'b1, '{32'd0, ST_UNKNOWN});
        // sizes that round to 2^32
        add_req(KIND_ALLOC, 32'hffff_fffd, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED});
        add_req(KIND_ALLOC, 32'hffff_ffff, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED});
        add_cfg(REG_HEAP_BASE, 32'hffff_ffff);
        add_req(KIND_ALLOC, 32'd1, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED});
        add_cfg(REG_HEAP_LIMIT, 32'd0);
        add_cfg(REG_HEAP_BASE, 32'd0);
        // writes to spare indexes must leave both registers alone
        add_cfg(REG_SPARE_LO, 32'd0);
        add_cfg(REG_SPARE_HI, 32'hffff_ffff);
        add_req(KIND_ALLOC, 32'd4, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED});
        add_cfg(REG_HEAP_LIMIT, 32'hffff_ffff);
        add_cfg(REG_HEAP_BASE, 32'h0000_1000);
        add_req(KIND_ALLOC, 32'd1, 32'd0, 1'b1, '{32'h0000_100c, ST_OK});
        add_req(KIND_ALLOC, 32'd5, 32'd0, 1'b0, '0);
        add_req(KIND_FREE, 32'd0, 32'h0000_100c, 1'b1, '{32'd0, ST_OK});
        add_req(KIND_FREE, 32'd0, 32'h0000_100c, 1'b1, '{32'd0, ST_OK});
        // header address rather than payload address
        add_req(KIND_FREE, 32'd0, 32'h0000_1010, 1'b1, '{32'd0, ST_UNKNOWN});
        add_req(KIND_ALLOC, 32'd8, 32'd0, 1'b0, '0);
        add_req(KIND_ALLOC, 32'd3, 32'd0, 1'b0, '0);
        add_req(KIND_FREE, 32'd0, 32'h0000_101c, 1'b1, '{32'd0, ST_OK});
        add_req(KIND_ALLOC, 32'hffff_fffc, 32'd0, 1'b1, '{32'd0, ST_EXHAUSTED});
        add_req(KIND_ALLOC, 32'd6, 32'd0, 1'b0, '0);
        add_req(KIND_FREE, 32'd0, 32'h0000_1030, 1'b1, '{32'd0, ST_OK});
        add_req(KIND_ALLOC, 32'd7, 32'd0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_CFG) begin
                set_register(dir_rows[r].index, dir_rows[r].data);
            end else begin
                send_request(dir_rows[r].kind, dir_rows[r].size, dir_rows[r].addr,
                             dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // tight limit just above the break so appends run out soon
        set_register(REG_HEAP_BASE, $urandom);
        set_register(REG_HEAP_LIMIT, limit_above_break(200, 600));
        repeat (300) random_request();

        // no room at all: only reuse of freed blocks succeeds
        set_register(REG_HEAP_BASE, 32'hffff_ffff);
        set_register(REG_HEAP_LIMIT, 32'd0);
        repeat (250) random_request();

        // open limit, no idling on either side; table fills up
        set_register(REG_HEAP_LIMIT, 32'hffff_ffff);
        calm = 1'b1;
        repeat (450) random_request();
        calm = 1'b0;

        set_register(REG_HEAP_BASE, $urandom);
        set_register(REG_HEAP_LIMIT, limit_above_break(0, 3000));
        repeat (430) random_request();

        i_valid <= 1'b0;
        drain_cycles = 0;
        while (grant_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (grant_q.size() != 0) begin
            $error("%0d results never arrived", grant_q.size());
            mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("requests %0d, results %0d: ok %0d, zero size %0d, exhausted %0d, full %0d, unknown %0d",
                 requests_sent, results_seen, status_seen[ST_OK], status_seen[ST_ZERO],
                 status_seen[ST_EXHAUSTED], status_seen[ST_FULL], status_seen[ST_UNKNOWN]);
        $display("blocks created %0d of %0d, final break %h, mismatches %0d",
                 heap_blocks, MAX_BLOCKS, heap_break, mismatches);
        if (mismatches == 0) begin
            $display("** first_fit_heap_allocator_core: PASSED **");
        end else begin
            $display("** first_fit_heap_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
